### src/koent_pkg.sv
// Package for the keyed node table: widths, action and state codes,
// the stored entry layout and the result record. No dependencies.
`default_nettype none

package koent_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int ID_W      = 32;
  localparam int TIME_W    = 32;
  localparam int KEY_W     = 64;
  localparam int KEY_WORDS = 4;
  localparam int COUNT_W   = 6;

  typedef enum logic [1:0] {
    ACT_ABSORB = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef logic [KEY_WORDS-1:0][KEY_W-1:0] key_t;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [TIME_W-1:0] heard_time;
    key_t              key;
  } entry_t;

  // what the scan has found so far
  typedef struct packed {
    logic match;
    logic empty;
    logic free_hit;
    logic keyed_hit;
  } scan_flags_t;

  typedef struct packed {
    logic               ok;
    logic               key_present;
    logic [ID_W-1:0]    found_id;
    logic [TIME_W-1:0]  found_time;
    key_t               key;
    logic [COUNT_W-1:0] occupied_count;
  } result_t;

  function automatic logic key_nz(input key_t k);
    return |k;
  endfunction

endpackage

`default_nettype wire

### src/koent_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module koent_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/koent_scan.sv
// Scan evaluator: looks at one read-back slot per cycle and keeps the id
// match, the first empty slot and the oldest keyless / keyed slots.
// Uses koent_pkg.
`default_nettype none

module koent_scan #(
  parameter int SLOTS = koent_pkg::SLOTS_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     init,
  input  wire logic                     dv,
  input  wire logic [AW-1:0]            didx,
  input  wire koent_pkg::entry_t        rdata,
  input  wire logic [koent_pkg::ID_W-1:0] req_id,
  output koent_pkg::scan_flags_t        flags,
  output logic      [AW-1:0]            match_idx,
  output logic      [AW-1:0]            empty_idx,
  output logic      [AW-1:0]            free_idx,
  output logic      [AW-1:0]            keyed_idx,
  output koent_pkg::entry_t             match_entry
);

  koent_pkg::scan_flags_t             flags_r;
  logic [AW-1:0]                      match_idx_r, empty_idx_r, free_idx_r, keyed_idx_r;
  logic [koent_pkg::TIME_W-1:0]       free_t_r, keyed_t_r;
  koent_pkg::entry_t                  match_e_r;
  logic                               id_nz, kd;
  logic                               hit_match, hit_empty, hit_free, hit_keyed;

  always_comb begin
    id_nz     = rdata.node_id != '0;
    kd        = koent_pkg::key_nz(rdata.key);
    hit_match = dv && (req_id != '0) && (rdata.node_id == req_id) && !flags_r.match;
    hit_empty = dv && !id_nz && !flags_r.empty;
    // strict compare keeps the lowest index on equal times
    hit_keyed = dv && id_nz && kd &&
                (!flags_r.keyed_hit || (rdata.heard_time < keyed_t_r));
    hit_free  = dv && id_nz && !kd &&
                (!flags_r.free_hit || (rdata.heard_time < free_t_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (init) begin
      flags_r <= '0;
    end else begin
      if (hit_match) flags_r.match     <= 1'b1;
      if (hit_empty) flags_r.empty     <= 1'b1;
      if (hit_free)  flags_r.free_hit  <= 1'b1;
      if (hit_keyed) flags_r.keyed_hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_match) begin
      match_idx_r <= didx;
      match_e_r   <= rdata;
    end
    if (hit_empty) begin
      empty_idx_r <= didx;
    end
    if (hit_free) begin
      free_idx_r <= didx;
      free_t_r   <= rdata.heard_time;
    end
    if (hit_keyed) begin
      keyed_idx_r <= didx;
      keyed_t_r   <= rdata.heard_time;
    end
  end

  assign flags       = flags_r;
  assign match_idx   = match_idx_r;
  assign empty_idx   = empty_idx_r;
  assign free_idx    = free_idx_r;
  assign keyed_idx   = keyed_idx_r;
  assign match_entry = match_e_r;

endmodule

`default_nettype wire

### src/keyed_oldest_evict_node_table_top.sv
// Keyed node table with oldest-timestamp replacement: sequencer, slot RAM
// and scan evaluator. Uses koent_pkg, koent_ram, koent_scan.
//
//   channel   handshake          payload
//   request   start / busy       in_action, in_node_id, in_heard_time, in_key_word0..3
//   result    out_valid strobe   out_ok, out_key_present, out_found_id, out_found_time,
//                                out_key0..3, out_occupied_count
//
// Absorb, take and lookup do one RAM read per slot through the single read
// port, with registered read data, then a write state in which absorb stores
// its entry and take clears the matched slot. Clear writes one slot per cycle.
// After reset the same clearing pass runs (busy high, no result). The result
// strobe lasts one cycle and cannot be held.
`default_nettype none

module keyed_oldest_evict_node_table_top #(
  parameter int SLOTS = koent_pkg::SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_action,
  input  wire logic [koent_pkg::ID_W-1:0]        in_node_id,
  input  wire logic [koent_pkg::TIME_W-1:0]      in_heard_time,
  input  wire logic [koent_pkg::KEY_W-1:0]       in_key_word0,
  input  wire logic [koent_pkg::KEY_W-1:0]       in_key_word1,
  input  wire logic [koent_pkg::KEY_W-1:0]       in_key_word2,
  input  wire logic [koent_pkg::KEY_W-1:0]       in_key_word3,
  output logic                                   out_valid,
  output logic                                   out_ok,
  output logic                                   out_key_present,
  output logic      [koent_pkg::ID_W-1:0]        out_found_id,
  output logic      [koent_pkg::TIME_W-1:0]      out_found_time,
  output logic      [koent_pkg::KEY_W-1:0]       out_key0,
  output logic      [koent_pkg::KEY_W-1:0]       out_key1,
  output logic      [koent_pkg::KEY_W-1:0]       out_key2,
  output logic      [koent_pkg::KEY_W-1:0]       out_key3,
  output logic      [koent_pkg::COUNT_W-1:0]     out_occupied_count
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);

  koent_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic               reply_r, reply_nxt;
  logic               dv_r;
  logic [AW-1:0]      didx_r;
  koent_pkg::act_t    req_act_r;
  koent_pkg::entry_t  req_e_r;
  koent_pkg::result_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  koent_pkg::entry_t  ram_wdata, ram_rdata;

  koent_pkg::scan_flags_t flags;
  logic [AW-1:0]      match_idx, empty_idx, free_idx, keyed_idx;
  koent_pkg::entry_t  match_e;
  logic               absorb_ok;
  logic [AW-1:0]      absorb_idx;

  assign accept = start && (state_r == koent_pkg::ST_IDLE);
  assign busy   = state_r != koent_pkg::ST_IDLE;

  koent_ram #(
    .WIDTH ($bits(koent_pkg::entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  koent_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .init        (accept),
    .dv          (dv_r),
    .didx        (didx_r),
    .rdata       (ram_rdata),
    .req_id      (req_e_r.node_id),
    .flags       (flags),
    .match_idx   (match_idx),
    .empty_idx   (empty_idx),
    .free_idx    (free_idx),
    .keyed_idx   (keyed_idx),
    .match_entry (match_e)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      koent_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (koent_pkg::act_t'(in_action) == koent_pkg::ACT_CLEAR) ?
                      koent_pkg::ST_CLEAR : koent_pkg::ST_SCAN;
        end
      end
      koent_pkg::ST_CLEAR: begin
        if (cnt_r == CNT_LAST) state_nxt = koent_pkg::ST_IDLE;
      end
      koent_pkg::ST_SCAN: begin
        if (cnt_r == CNT_END) state_nxt = koent_pkg::ST_WRITE;
      end
      koent_pkg::ST_WRITE: begin
        state_nxt = koent_pkg::ST_IDLE;
      end
      default: state_nxt = koent_pkg::ST_IDLE;
    endcase
  end

  // absorb target: existing id, first empty, oldest keyless, oldest keyed (keyed request only); zero id fails
  always_comb begin
    absorb_ok  = 1'b0;
    absorb_idx = match_idx;
    priority if (req_e_r.node_id == '0) begin
      absorb_ok = 1'b0;
    end else if (flags.match) begin
      absorb_ok  = 1'b1;
      absorb_idx = match_idx;
    end else if (flags.empty) begin
      absorb_ok  = 1'b1;
      absorb_idx = empty_idx;
    end else if (flags.free_hit) begin
      absorb_ok  = 1'b1;
      absorb_idx = free_idx;
    end else if (koent_pkg::key_nz(req_e_r.key) && flags.keyed_hit) begin
      absorb_ok  = 1'b1;
      absorb_idx = keyed_idx;
    end else begin
      absorb_ok = 1'b0;
    end
  end

  // outputs, RAM control, counters
  always_comb begin
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    reply_nxt     = reply_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r[AW-1:0];
    unique case (state_r)
      koent_pkg::ST_IDLE: begin
        if (start) begin
          cnt_nxt   = '0;
          reply_nxt = 1'b1;
        end
      end
      koent_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        used_nxt = '0;
        if (cnt_r == CNT_LAST && reply_r) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.ok    = 1'b1;
        end
      end
      koent_pkg::ST_SCAN: begin
        if (cnt_r != CNT_END) begin
          ram_re  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      koent_pkg::ST_WRITE: begin
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        unique case (req_act_r)
          koent_pkg::ACT_ABSORB: begin
            res_nxt.ok = absorb_ok;
            if (absorb_ok) begin
              ram_we    = 1'b1;
              ram_waddr = absorb_idx;
              ram_wdata = req_e_r;
              if (!flags.match && flags.empty) used_nxt = used_r + 1'b1;
            end
          end
          koent_pkg::ACT_TAKE: begin
            if (flags.match) begin
              res_nxt.ok          = 1'b1;
              res_nxt.key_present = koent_pkg::key_nz(match_e.key);
              res_nxt.found_id    = match_e.node_id;
              res_nxt.found_time  = match_e.heard_time;
              res_nxt.key         = match_e.key;
              ram_we              = 1'b1;
              ram_waddr           = match_idx;
              used_nxt            = used_r - 1'b1;
            end
          end
          koent_pkg::ACT_LOOKUP: begin
            if (flags.match) begin
              res_nxt.ok          = 1'b1;
              res_nxt.key_present = koent_pkg::key_nz(match_e.key);
              res_nxt.key         = match_e.key;
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
        res_nxt.occupied_count = koent_pkg::COUNT_W'(used_nxt);
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= koent_pkg::ST_CLEAR;
      cnt_r       <= '0;
      used_r      <= '0;
      reply_r     <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      reply_r     <= reply_nxt;
      dv_r        <= ram_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= ram_raddr;
    res_r  <= res_nxt;
    if (accept) begin
      req_act_r          <= koent_pkg::act_t'(in_action);
      req_e_r.node_id    <= in_node_id;
      req_e_r.heard_time <= in_heard_time;
      req_e_r.key        <= {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = res_r.ok;
  assign out_key_present    = res_r.key_present;
  assign out_found_id       = res_r.found_id;
  assign out_found_time     = res_r.found_time;
  assign out_key0           = res_r.key[0];
  assign out_key1           = res_r.key[1];
  assign out_key2           = res_r.key[2];
  assign out_key3           = res_r.key[3];
  assign out_occupied_count = res_r.occupied_count;

endmodule

`default_nettype wire

### src/koent_chk.sv
// Port-level checker for the keyed node table top, bound to it below.
// Uses only the top level's ports.
`default_nettype none

module koent_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_ok,
  input wire logic        out_key_present,
  input wire logic [31:0] out_found_id,
  input wire logic [31:0] out_found_time,
  input wire logic [63:0] out_key0,
  input wire logic [63:0] out_key1,
  input wire logic [63:0] out_key2,
  input wire logic [63:0] out_key3
);

  // an accepted request always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after an accepted request");

  // strobe comes when the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> !out_key_present && out_found_id == '0 &&
      out_found_time == '0 && out_key0 == '0 && out_key1 == '0 &&
      out_key2 == '0 && out_key3 == '0)
    else $error("failed request carries nonzero fields");

  a_nokey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_present |-> out_key0 == '0 && out_key1 == '0 &&
      out_key2 == '0 && out_key3 == '0)
    else $error("key fields nonzero without key_present");

endmodule

bind keyed_oldest_evict_node_table_top koent_chk u_koent_chk (.*);

`default_nettype wire
